// ===== hw/rtl/touchpad_report_to_panel_touch_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch: assertion macros
// Assertion wrappers shared by the RTL; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef TOUCHPAD_REPORT_TO_PANEL_TOUCH_UNIT_MACROS_SVH
`define TOUCHPAD_REPORT_TO_PANEL_TOUCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define TPRPT_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("tprpt assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define TPRPT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("tprpt assertion failed");

`else

`define TPRPT_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define TPRPT_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== hw/rtl/tprpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch: shared package
// Types, codes and scaling constants used by all modules of the block.
// ----------------------------------------------------------------------------
package tprpt_pkg;

    // Mode register codes.
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_FRONT   = 2'd1,
        MODE_TOGGLE2 = 2'd2,
        MODE_TOGGLE3 = 2'd3
    } mode_t;

    // Panel codes, two's complement: -1 none, 0 front, 1 back.
    typedef logic [1:0] panel_t;
    localparam panel_t PANEL_FRONT = 2'b00;
    localparam panel_t PANEL_BACK  = 2'b01;
    localparam panel_t PANEL_NONE  = 2'b11;

    // Which coordinate a scaling lane handles.
    typedef enum logic {
        AXIS_COL = 1'b0,
        AXIS_ROW = 1'b1
    } axis_t;

    // Register addresses.
    localparam logic ADDR_TOUCH_MODE = 1'b0;

    // Field widths.
    localparam int unsigned RAW_W   = 12;
    localparam int unsigned COORD_W = 11;
    localparam int unsigned TAG_W   = 7;
    localparam int unsigned PROD_W  = 22;
    localparam int unsigned RECIP_W = 24;

    // Pad geometry and panel spans.
    localparam int unsigned PAD_OFS_COL    = 0 + 60;
    localparam int unsigned PAD_OFS_ROW    = 0 + 120;
    localparam int unsigned PAD_W          = 1920 - 2*60;
    localparam int unsigned PAD_H          = 942 - 2*120;
    localparam int unsigned COL_SPAN       = 960*2 - 1;
    localparam int unsigned FRONT_ROW_SPAN = 544*2 - 1;
    localparam int unsigned BACK_ROW_SPAN  = 445*2 - 54*2 - 1;
    localparam int unsigned BACK_ROW_OFS   = 54*2;
    localparam int unsigned COL_DIV        = PAD_W - 1;
    localparam int unsigned ROW_DIV        = PAD_H - 1;

    // Reciprocals rounded up; with a product below 2^22 and a divisor below
    // 2^11 the shift of 33 makes the quotient exact for every input.
    localparam int unsigned RECIP_SHIFT = 33;
    localparam logic [63:0] COL_RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(COL_DIV) - 64'd1) / 64'(COL_DIV);
    localparam logic [63:0] ROW_RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(ROW_DIV) - 64'd1) / 64'(ROW_DIV);
    localparam logic [RECIP_W-1:0] COL_RECIP = RECIP_W'(COL_RECIP_FULL);
    localparam logic [RECIP_W-1:0] ROW_RECIP = RECIP_W'(ROW_RECIP_FULL);

    // Panel decision for one accepted report.
    typedef struct packed {
        logic   emit;
        panel_t panel;
    } ctrl_t;

    // One result, packed as it leaves on the master side (lowest field last).
    typedef struct packed {
        logic [COORD_W-1:0] slot1_row;
        logic [COORD_W-1:0] slot1_col;
        logic [TAG_W-1:0]   slot1_tag;
        logic [COORD_W-1:0] slot0_row;
        logic [COORD_W-1:0] slot0_col;
        logic [TAG_W-1:0]   slot0_tag;
        logic [1:0]         touch_count;
        panel_t             panel;
    } result_t;

endpackage

// ===== hw/rtl/touchpad_report_to_panel_touch_unit.sv =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch
// Touchpad reports to slot-packed panel touches, one a cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one touchpad report per clock cycle unless the master side
// holds results back and, for the last report of a batch, presents one result
// on the master side. The panel decision, clamp and span multiply work on the
// beat in the cycle it is accepted and are registered with it; the reciprocal
// multiply in the four scaling lanes (column and row of each finger) feeds
// the middle stage registers, and the slot merge the output register. Each
// stage has its own valid bit, so a report is taken whenever the stage behind
// the input has room, even while a result waits on the master side; reports
// that are not a batch end, or arrive with the mode off, leave no result. The
// mode register sits at byte address 0 of the configuration port.
`include "touchpad_report_to_panel_touch_unit_macros.svh"

module touchpad_report_to_panel_touch_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Slave side. tdata from bit 0: pad_button, first_finger_absent,
    // first_finger_tag[6:0], first_finger_col[11:0], first_finger_row[11:0],
    // second_finger_absent, second_finger_tag[6:0], second_finger_col[11:0],
    // second_finger_row[11:0], zero fill. tlast: batch_end.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tlast,
    // Master side. tdata from bit 0: panel[1:0], touch_count[1:0],
    // slot0_tag[6:0], slot0_col[10:0], slot0_row[10:0], slot1_tag[6:0],
    // slot1_col[10:0], slot1_row[10:0], zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tprpt_pkg::*;

    mode_t                     mode_reg;
    ctrl_t                     ctrl;
    logic                      s_fire;
    logic                      va_reg;
    logic                      vb_reg;
    logic                      vo_reg;
    logic                      ready_a;
    logic                      ready_b;
    logic                      ready_o;
    logic [1:0]                absent_in;
    logic [1:0][TAG_W-1:0]     tag_in;
    logic [1:0][RAW_W-1:0]     col_in;
    logic [1:0][RAW_W-1:0]     row_in;
    panel_t                    panel_a_reg;
    logic [1:0]                absent_a_reg;
    logic [1:0][TAG_W-1:0]     tag_a_reg;
    panel_t                    panel_b_reg;
    logic [1:0]                absent_b_reg;
    logic [1:0][TAG_W-1:0]     tag_b_reg;
    logic [1:0][COORD_W-1:0]   col_b;
    logic [1:0][COORD_W-1:0]   row_b;
    result_t                   result;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TOUCH_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_TOUCH_MODE))
        begin
            mode_reg <= mode_t'(pwdata[1:0]);
        end
    end

    // Input beat unpacking.
    assign absent_in[0] = s_tdata[1];
    assign tag_in[0]    = s_tdata[8:2];
    assign col_in[0]    = s_tdata[20:9];
    assign row_in[0]    = s_tdata[32:21];
    assign absent_in[1] = s_tdata[33];
    assign tag_in[1]    = s_tdata[40:34];
    assign col_in[1]    = s_tdata[52:41];
    assign row_in[1]    = s_tdata[64:53];

    // Stage handshake: each stage moves when the one behind it has room.
    assign ready_o  = !vo_reg || m_tready;
    assign ready_b  = !vb_reg || ready_o;
    assign ready_a  = !va_reg || ready_b;
    assign s_tready = ready_a;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= s_fire && ctrl.emit;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_o)
            begin
                vo_reg <= vb_reg;
            end
        end
    end

    // Panel tracking.
    tprpt_panel_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .fire       (s_fire),
        .pad_button (s_tdata[0]),
        .batch_end  (s_tlast),
        .ctrl       (ctrl)
    );

    // Sideband carried alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            panel_a_reg  <= ctrl.panel;
            absent_a_reg <= absent_in;
            tag_a_reg    <= tag_in;
        end
        if (ready_b)
        begin
            panel_b_reg  <= panel_a_reg;
            absent_b_reg <= absent_a_reg;
            tag_b_reg    <= tag_a_reg;
        end
    end

    // One column lane and one row lane per finger.
    for (genvar g = 0; g < 2; g++)
    begin : g_finger
        tprpt_scale_lane u_col (
            .clk   (clk),
            .en_a  (ready_a),
            .en_b  (ready_b),
            .axis  (AXIS_COL),
            .back  (ctrl.panel == PANEL_BACK),
            .raw   (col_in[g]),
            .coord (col_b[g])
        );
        tprpt_scale_lane u_row (
            .clk   (clk),
            .en_a  (ready_a),
            .en_b  (ready_b),
            .axis  (AXIS_ROW),
            .back  (ctrl.panel == PANEL_BACK),
            .raw   (row_in[g]),
            .coord (row_b[g])
        );
    end

    // Slot merge and output register.
    tprpt_merge u_merge (
        .clk    (clk),
        .en     (ready_o),
        .panel  (panel_b_reg),
        .absent (absent_b_reg),
        .tag    (tag_b_reg),
        .col    (col_b),
        .row    (row_b),
        .result (result)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = {2'd0, result};

    // A beat taken with the mode off never starts a result.
    `TPRPT_ASSERT_NEXT(a_off_no_result, clk, rst_n,
        s_fire && (mode_reg == MODE_OFF), !va_reg)

    // With no active panel the result carries no touches.
    `TPRPT_ASSERT_SAME(a_none_empty, clk, rst_n,
        vo_reg && (result.panel == PANEL_NONE), result.touch_count == 2'd0)

    // Back-panel rows always carry the back offset.
    `TPRPT_ASSERT_SAME(a_back_row_ofs, clk, rst_n,
        vo_reg && (result.panel == PANEL_BACK) && (result.touch_count != 2'd0),
        result.slot0_row >= COORD_W'(BACK_ROW_OFS))

    // A blocked middle stage keeps its item.
    `TPRPT_ASSERT_NEXT(a_stage_b_hold, clk, rst_n, vb_reg && !ready_b, vb_reg)

endmodule

// ===== hw/rtl/tprpt_panel_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch: panel control
// Tracks the click level and the active panel, and decides whether a report
// produces a result.
// ----------------------------------------------------------------------------
module tprpt_panel_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  tprpt_pkg::mode_t mode,
    input  logic            fire,
    input  logic            pad_button,
    input  logic            batch_end,
    output tprpt_pkg::ctrl_t ctrl
);
    import tprpt_pkg::*;

    logic   button_was_down_reg;
    logic   button_was_down_next;
    panel_t panel_reg;
    panel_t panel_next;
    logic   rising;

    // Panel advance on a rising click edge.
    always_comb
    begin
        rising               = pad_button && !button_was_down_reg;
        button_was_down_next = pad_button;
        panel_next           = panel_reg;
        if (rising && (mode != MODE_FRONT))
        begin
            if (panel_reg == PANEL_BACK)
            begin
                panel_next = (mode == MODE_TOGGLE2) ? PANEL_FRONT : PANEL_NONE;
            end
            else
            begin
                panel_next = panel_reg + 2'd1;
            end
        end
        ctrl.panel = panel_next;
        ctrl.emit  = (mode != MODE_OFF) && batch_end;
    end

    // State only moves on beats taken while the mode is not off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_was_down_reg <= 1'b0;
            panel_reg           <= PANEL_FRONT;
        end
        else if (fire && (mode != MODE_OFF))
        begin
            button_was_down_reg <= button_was_down_next;
            panel_reg           <= panel_next;
        end
    end

endmodule

// ===== hw/rtl/tprpt_scale_lane.sv =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch: coordinate scaling lane
// Removes the dead-zone offset, clamps, and rescales one coordinate to the
// panel range in two registered stages.
// ----------------------------------------------------------------------------
module tprpt_scale_lane (
    input  logic                           clk,
    input  logic                           en_a,
    input  logic                           en_b,
    input  tprpt_pkg::axis_t               axis,
    input  logic                           back,
    input  logic [tprpt_pkg::RAW_W-1:0]    raw,
    output logic [tprpt_pkg::COORD_W-1:0]  coord
);
    import tprpt_pkg::*;

    localparam int unsigned FULL_W = PROD_W + RECIP_W;

    logic [RAW_W-1:0]   ofs;
    logic [RAW_W-1:0]   diff;
    logic [COORD_W-1:0] lim;
    logic [COORD_W-1:0] clamped;
    logic [COORD_W-1:0] gain;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic               back_reg;
    logic [RECIP_W-1:0] recip;
    logic [FULL_W-1:0]  full;
    logic [COORD_W-1:0] bias;
    logic [COORD_W-1:0] coord_reg;
    logic [COORD_W-1:0] coord_next;

    // Offset removal, clamp and multiplication by the panel span.
    always_comb
    begin
        ofs  = (axis == AXIS_COL) ? RAW_W'(PAD_OFS_COL) : RAW_W'(PAD_OFS_ROW);
        lim  = (axis == AXIS_COL) ? COORD_W'(PAD_W - 1) : COORD_W'(PAD_H - 1);
        diff = raw - ofs;
        if (raw < ofs)
        begin
            clamped = '0;
        end
        else if (diff > RAW_W'(lim))
        begin
            clamped = lim;
        end
        else
        begin
            clamped = diff[COORD_W-1:0];
        end
        if (axis == AXIS_COL)
        begin
            gain = COORD_W'(COL_SPAN);
        end
        else
        begin
            gain = back ? COORD_W'(BACK_ROW_SPAN) : COORD_W'(FRONT_ROW_SPAN);
        end
        prod_next = PROD_W'(clamped) * PROD_W'(gain);
    end

    // Division by the pad span as an exact reciprocal multiply and shift.
    always_comb
    begin
        recip      = (axis == AXIS_COL) ? COL_RECIP : ROW_RECIP;
        full       = FULL_W'(prod_reg) * FULL_W'(recip);
        bias       = ((axis == AXIS_ROW) && back_reg) ? COORD_W'(BACK_ROW_OFS) : '0;
        coord_next = full[RECIP_SHIFT +: COORD_W] + bias;
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            prod_reg <= prod_next;
            back_reg <= back;
        end
        if (en_b)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

// ===== hw/rtl/tprpt_merge.sv =====
// ----------------------------------------------------------------------------
// Touchpad report to panel touch: slot merge
// Packs the present fingers of the lanes into slots in order and holds the
// finished result in the output register.
// ----------------------------------------------------------------------------
module tprpt_merge (
    input  logic                                clk,
    input  logic                                en,
    input  tprpt_pkg::panel_t                   panel,
    input  logic [1:0]                          absent,
    input  logic [1:0][tprpt_pkg::TAG_W-1:0]    tag,
    input  logic [1:0][tprpt_pkg::COORD_W-1:0]  col,
    input  logic [1:0][tprpt_pkg::COORD_W-1:0]  row,
    output tprpt_pkg::result_t                  result
);
    import tprpt_pkg::*;

    result_t result_reg;
    result_t result_next;

    // Slot packing: the first present finger takes the first slot.
    always_comb
    begin
        result_next       = '0;
        result_next.panel = panel;
        if (panel != PANEL_NONE)
        begin
            if (!absent[0])
            begin
                result_next.slot0_tag   = tag[0];
                result_next.slot0_col   = col[0];
                result_next.slot0_row   = row[0];
                result_next.touch_count = 2'd1;
                if (!absent[1])
                begin
                    result_next.slot1_tag   = tag[1];
                    result_next.slot1_col   = col[1];
                    result_next.slot1_row   = row[1];
                    result_next.touch_count = 2'd2;
                end
            end
            else if (!absent[1])
            begin
                result_next.slot0_tag   = tag[1];
                result_next.slot0_col   = col[1];
                result_next.slot0_row   = row[1];
                result_next.touch_count = 2'd1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
